// ===== rtl/rotated_sorted_array_search_unit_assert.svh =====
// Assertion macros for the rotated sorted array search unit.
`ifndef ROTATED_SORTED_ARRAY_SEARCH_UNIT_ASSERT_SVH
`define ROTATED_SORTED_ARRAY_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RSAS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RSAS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rsas_pkg.sv =====
// Shared types and constants of the rotated sorted array search unit.
package rsas_pkg;

    localparam int MAX_ELEMENTS_DEF = 128;
    localparam int DATA_W           = 32;
    localparam int ADDR_W           = 7;
    localparam int LEN_W            = 8;
    localparam int POS_W            = 7;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef logic [LEN_W-1:0] len_t;

    typedef struct packed {
        logic                     mode;
        logic [ADDR_W-1:0]        address;
        logic signed [DATA_W-1:0] data;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } rsp_t;

endpackage

// ===== rtl/rsas_chan_if.sv =====
// Valid/ready channel carrying one payload per beat.
interface rsas_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/rotated_sorted_array_search_unit.sv =====
// Top level of the rotated sorted array search unit.
//
//   channel  dir  beat payload                        handshake
//   cfg      in   array_length (8b)                  valid/ready, always ready
//   req      in   mode, address (7b), data (32b s)   valid/ready
//   rsp      out  found, position (7b)               valid/ready, output register
//
// A write beat gives no result.
// A search reads the last element, probes for the rotation point (a second read at mid+1
// unless mid is the last index), then binary-searches the lower run and, on a miss, the
// upper run, or the whole array if no rotation point turns up, all through one read port.
// rst_n clears control and sets array_length to 1; the store holds no reset value.
// A waiting result does not block the next beat; a finished search waits for the slot.
`include "rotated_sorted_array_search_unit_assert.svh"

module rotated_sorted_array_search_unit #(
    parameter int MAX_ELEMENTS = rsas_pkg::MAX_ELEMENTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    rsas_chan_if.sink     cfg,
    rsas_chan_if.sink     req,
    rsas_chan_if.source   rsp
);

    localparam int IW   = $clog2(MAX_ELEMENTS);
    localparam int NW   = IW + 1;
    localparam int CW   = IW + 2;
    localparam int LW   = (NW > rsas_pkg::LEN_W) ? NW : rsas_pkg::LEN_W;
    localparam int AW_C = (NW > rsas_pkg::ADDR_W) ? NW : rsas_pkg::ADDR_W;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_LAST_RD = 9'b000000010,
        ST_LAST_WT = 9'b000000100,
        ST_ROT_RD  = 9'b000001000,
        ST_ROT_WT  = 9'b000010000,
        ST_ROT_NXT = 9'b000100000,
        ST_RUN_RD  = 9'b001000000,
        ST_RUN_WT  = 9'b010000000,
        ST_DONE    = 9'b100000000
    } state_t;

    state_t                              state_reg, state_next;
    rsas_pkg::len_t                      len_reg;
    logic [NW-1:0]                       n_reg, n_next;
    logic signed [CW-1:0]                lo_reg, lo_next, hi_reg, hi_next;
    logic signed [rsas_pkg::DATA_W-1:0]  key_reg, key_next;
    logic signed [rsas_pkg::DATA_W-1:0]  last_reg, last_next;
    logic signed [rsas_pkg::DATA_W-1:0]  m_reg, m_next;
    logic [IW-1:0]                       rot_reg, rot_next;
    logic                                second_reg, second_next;
    logic                                res_found_reg, res_found_next;
    logic [rsas_pkg::POS_W-1:0]          res_pos_reg, res_pos_next;
    logic                                out_vld_reg;
    rsas_pkg::rsp_t                      out_reg;

    logic [LW-1:0]                       len_ext;
    logic [LW-1:0]                       neff_l;
    logic [NW-1:0]                       neff;
    logic [AW_C-1:0]                     addr_ext;
    logic                                req_acc;
    logic                                wr_en;
    logic                                rd_en;
    logic [IW-1:0]                       rd_addr;
    logic signed [rsas_pkg::DATA_W-1:0]  rd_data;
    logic signed [CW-1:0]                sum;
    logic [IW-1:0]                       mid;
    logic signed [CW-1:0]                mid_s;
    logic signed [CW-1:0]                n_s;
    logic                                lo_le_hi;
    logic                                mid_lt_last;
    logic                                out_load;

    // effective length: 0 acts as 1, clamp to the store depth
    always_comb
    begin
        len_ext = LW'(len_reg);
        if (len_ext == '0)
        begin
            neff_l = LW'(1);
        end
        else if (len_ext > LW'(MAX_ELEMENTS))
        begin
            neff_l = LW'(MAX_ELEMENTS);
        end
        else
        begin
            neff_l = len_ext;
        end
        neff = NW'(neff_l);
    end

    assign addr_ext = AW_C'(req.payload.address);
    assign req_acc  = req.valid && req.ready;
    assign wr_en    = req_acc && (req.payload.mode == rsas_pkg::MODE_WRITE)
                      && (addr_ext < AW_C'(MAX_ELEMENTS));

    assign sum         = lo_reg + hi_reg;
    assign mid         = sum[IW:1];
    assign mid_s       = $signed(CW'(mid));
    assign n_s         = $signed(CW'(n_reg));
    assign lo_le_hi    = (lo_reg <= hi_reg);
    assign mid_lt_last = ((NW'(mid) + NW'(1)) < n_reg);
    assign out_load    = (state_reg == ST_DONE) && (!out_vld_reg || rsp.ready);

    rsas_store #(
        .DEPTH (MAX_ELEMENTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr_ext[IW-1:0]),
        .wr_data (req.payload.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        key_next       = key_reg;
        last_next      = last_reg;
        m_next         = m_reg;
        rot_next       = rot_reg;
        second_next    = second_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        rd_en          = 1'b0;
        rd_addr        = mid;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_acc && (req.payload.mode == rsas_pkg::MODE_SEARCH))
                begin
                    n_next     = neff;
                    lo_next    = '0;
                    hi_next    = $signed(CW'(neff)) - CW'(1);
                    key_next   = req.payload.data;
                    state_next = ST_LAST_RD;
                end
            end
            ST_LAST_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = IW'(n_reg - NW'(1));
                state_next = ST_LAST_WT;
            end
            ST_LAST_WT:
            begin
                last_next  = rd_data;
                state_next = ST_ROT_RD;
            end
            ST_ROT_RD:
            begin
                if (lo_le_hi)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_ROT_WT;
                end
                else
                begin
                    // no rotation: one pass over the whole array
                    lo_next     = '0;
                    hi_next     = n_s - CW'(1);
                    second_next = 1'b1;
                    state_next  = ST_RUN_RD;
                end
            end
            ST_ROT_WT:
            begin
                m_next = rd_data;
                if (mid_lt_last)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = mid + IW'(1);
                    state_next = ST_ROT_NXT;
                end
                else
                begin
                    if (rd_data > last_reg)
                    begin
                        lo_next = mid_s + CW'(1);
                    end
                    else
                    begin
                        hi_next = mid_s - CW'(1);
                    end
                    state_next = ST_ROT_RD;
                end
            end
            ST_ROT_NXT:
            begin
                if (m_reg > rd_data)
                begin
                    rot_next    = mid;
                    lo_next     = '0;
                    hi_next     = mid_s;
                    second_next = 1'b0;
                    state_next  = ST_RUN_RD;
                end
                else
                begin
                    if (m_reg > last_reg)
                    begin
                        lo_next = mid_s + CW'(1);
                    end
                    else
                    begin
                        hi_next = mid_s - CW'(1);
                    end
                    state_next = ST_ROT_RD;
                end
            end
            ST_RUN_RD:
            begin
                if (lo_le_hi)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_RUN_WT;
                end
                else if (!second_reg)
                begin
                    // key not in the lower run: search the upper run
                    lo_next     = $signed(CW'(rot_reg)) + CW'(1);
                    hi_next     = n_s - CW'(1);
                    second_next = 1'b1;
                end
                else
                begin
                    res_found_next = 1'b0;
                    res_pos_next   = '0;
                    state_next     = ST_DONE;
                end
            end
            ST_RUN_WT:
            begin
                if (rd_data == key_reg)
                begin
                    res_found_next = 1'b1;
                    res_pos_next   = rsas_pkg::POS_W'(mid);
                    state_next     = ST_DONE;
                end
                else
                begin
                    if (rd_data > key_reg)
                    begin
                        hi_next = mid_s - CW'(1);
                    end
                    else
                    begin
                        lo_next = mid_s + CW'(1);
                    end
                    state_next = ST_RUN_RD;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            len_reg     <= rsas_pkg::len_t'(1);
            out_vld_reg <= 1'b0;
            second_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
            if (cfg.valid && cfg.ready)
            begin
                len_reg <= cfg.payload;
            end
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        key_reg       <= key_next;
        last_reg      <= last_next;
        m_reg         <= m_next;
        rot_reg       <= rot_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        if (out_load)
        begin
            out_reg.found    <= res_found_reg;
            out_reg.position <= res_pos_reg;
        end
    end

    assign cfg.ready   = 1'b1;
    assign req.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = out_vld_reg;
    assign rsp.payload = out_reg;

    `RSAS_ASSERT_IMP(a_miss_pos_zero, clk, rst_n, rsp.valid && !rsp.payload.found, rsp.payload.position == '0, "miss result carries a nonzero position")
    `RSAS_ASSERT_IMP(a_run_bounds, clk, rst_n, state_reg == ST_RUN_RD, (hi_reg < n_s) && (lo_reg <= n_s) && (lo_reg >= 0), "run bounds left the array")
    `RSAS_ASSERT_NXT(a_search_starts, clk, rst_n, req_acc && (req.payload.mode == rsas_pkg::MODE_SEARCH), state_reg == ST_LAST_RD, "search beat did not start a search")
    `RSAS_ASSERT_NXT(a_write_one_cycle, clk, rst_n, req_acc && (req.payload.mode == rsas_pkg::MODE_WRITE), state_reg == ST_IDLE, "write beat left the idle state")

endmodule

// ===== rtl/rsas_store.sv =====
// Element store: one write port, one read port with registered read data.
module rsas_store #(
    parameter int DEPTH = rsas_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [$clog2(DEPTH)-1:0]        wr_addr,
    input  logic [rsas_pkg::DATA_W-1:0]     wr_data,
    input  logic                            rd_en,
    input  logic [$clog2(DEPTH)-1:0]        rd_addr,
    output logic [rsas_pkg::DATA_W-1:0]     rd_data
);

    logic [rsas_pkg::DATA_W-1:0] mem [DEPTH];
    logic [rsas_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
